FILE: src/rfpf_pkg.sv
// Shared types, register map and microcode ROM of the resonant four-pole filter.
`default_nettype none
package rfpf_pkg;

   // Configuration register map
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_CUTOFF   = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_MODE     = 2'd2;

   localparam int CFG_COEFF_BITS = 16;
   localparam int MODE_BITS      = 2;

   localparam logic [CFG_COEFF_BITS-1:0] CUTOFF_RESET   = 16'd8192;
   localparam logic [CFG_COEFF_BITS-1:0] FEEDBACK_RESET = 16'd0;

   localparam logic [MODE_BITS-1:0] MODE_LOWPASS  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BANDPASS = 2'd2;

   typedef struct packed {
      logic [CFG_COEFF_BITS-1:0] cutoff;
      logic [CFG_COEFF_BITS-1:0] feedback;
      logic [MODE_BITS-1:0]      mode;
   } cfg_type;

   // Datapath operations, one per microcode step
   typedef enum logic [2:0] {
      OP_LOAD_IN,   // wait for and capture the input sample
      OP_DIFF_FB,   // diff = sat(s0 - s1) for the resonance term
      OP_MUL_FB,    // prod = fb * diff
      OP_TARGET,    // diff = sat(sat(x - s0) + (prod >> fb frac))
      OP_MUL_A,     // prod = a * diff
      OP_UPDATE,    // new = sat(s + (prod >> coeff bits)), rotate stage ring
      OP_DIFF,      // diff = sat(prev_new - s)
      OP_OUTPUT     // load the output register
   } alu_op_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_RSP_BUSY
   } cond_type;

   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_LAST  = 4'd15;

   typedef struct packed {
      alu_op_type           op;
      cond_type             cond;
      logic [STEP_BITS-1:0] target;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_busy;
   } status_type;

   // Microcode ROM: jump is taken while the condition holds
   function automatic uword_type ucode(input logic [STEP_BITS-1:0] step);
      uword_type word;
      case (step)
         4'd0:  word = '{OP_LOAD_IN, COND_NO_REQ,   STEP_FIRST};
         4'd1:  word = '{OP_DIFF_FB, COND_NEVER,    STEP_FIRST};
         4'd2:  word = '{OP_MUL_FB,  COND_NEVER,    STEP_FIRST};
         4'd3:  word = '{OP_TARGET,  COND_NEVER,    STEP_FIRST};
         4'd4:  word = '{OP_MUL_A,   COND_NEVER,    STEP_FIRST};
         4'd5:  word = '{OP_UPDATE,  COND_NEVER,    STEP_FIRST};
         4'd6:  word = '{OP_DIFF,    COND_NEVER,    STEP_FIRST};
         4'd7:  word = '{OP_MUL_A,   COND_NEVER,    STEP_FIRST};
         4'd8:  word = '{OP_UPDATE,  COND_NEVER,    STEP_FIRST};
         4'd9:  word = '{OP_DIFF,    COND_NEVER,    STEP_FIRST};
         4'd10: word = '{OP_MUL_A,   COND_NEVER,    STEP_FIRST};
         4'd11: word = '{OP_UPDATE,  COND_NEVER,    STEP_FIRST};
         4'd12: word = '{OP_DIFF,    COND_NEVER,    STEP_FIRST};
         4'd13: word = '{OP_MUL_A,   COND_NEVER,    STEP_FIRST};
         4'd14: word = '{OP_UPDATE,  COND_NEVER,    STEP_FIRST};
         4'd15: word = '{OP_OUTPUT,  COND_RSP_BUSY, STEP_LAST};
         default: word = '{OP_LOAD_IN, COND_NO_REQ, STEP_FIRST};
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

FILE: src/rfpf_req_if.sv
// Input sample channel: valid/ready handshake with one sample.
`default_nettype none
interface rfpf_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

FILE: src/rfpf_rsp_if.sv
// Result sample channel: valid/ready handshake with one filtered sample.
`default_nettype none
interface rfpf_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

FILE: src/rfpf_csr.sv
// APB-style configuration registers: cutoff coefficient, feedback gain, mode.
`default_nettype none
module rfpf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rfpf_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [rfpf_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [rfpf_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output rfpf_pkg::cfg_type                   cfg
);
   rfpf_pkg::cfg_type                    cfg_ff;
   rfpf_pkg::cfg_type                    cfg_in;
   logic                                 wr_en;
   logic [rfpf_pkg::REG_IDX_BITS-1:0]    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[rfpf_pkg::CSR_ADDR_BITS-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rfpf_pkg::REG_CUTOFF:
               cfg_in.cutoff = pwdata[rfpf_pkg::CFG_COEFF_BITS-1:0];
            rfpf_pkg::REG_FEEDBACK:
               cfg_in.feedback = pwdata[rfpf_pkg::CFG_COEFF_BITS-1:0];
            rfpf_pkg::REG_MODE:
               cfg_in.mode = pwdata[rfpf_pkg::MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff   <= rfpf_pkg::CUTOFF_RESET;
         cfg_ff.feedback <= rfpf_pkg::FEEDBACK_RESET;
         cfg_ff.mode     <= rfpf_pkg::MODE_LOWPASS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         rfpf_pkg::REG_CUTOFF:   prdata[rfpf_pkg::CFG_COEFF_BITS-1:0] = cfg_ff.cutoff;
         rfpf_pkg::REG_FEEDBACK: prdata[rfpf_pkg::CFG_COEFF_BITS-1:0] = cfg_ff.feedback;
         rfpf_pkg::REG_MODE:     prdata[rfpf_pkg::MODE_BITS-1:0]      = cfg_ff.mode;
         default:                prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

FILE: src/rfpf_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
`default_nettype none
module rfpf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  rfpf_pkg::status_type  status,
   output rfpf_pkg::alu_op_type  op
);
   logic [rfpf_pkg::STEP_BITS-1:0] step_ff;
   logic [rfpf_pkg::STEP_BITS-1:0] step_in;
   rfpf_pkg::uword_type            uword;
   logic                           jump;

   assign uword = rfpf_pkg::ucode(step_ff);

   always_comb begin
      case (uword.cond)
         rfpf_pkg::COND_NEVER:    jump = 1'b0;
         rfpf_pkg::COND_NO_REQ:   jump = !status.req_valid;
         rfpf_pkg::COND_RSP_BUSY: jump = status.rsp_busy;
         default:                 jump = 1'b0;
      endcase
      // last step wraps to the first through the increment
      step_in = jump ? uword.target : step_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rfpf_pkg::STEP_FIRST;
      end else begin
         step_ff <= step_in;
      end
   end

   assign op = uword.op;
endmodule
`default_nettype wire

FILE: src/rfpf_datapath.sv
// Filter datapath: stage ring, shared multiplier, saturating adder, output register.
`default_nettype none
module rfpf_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 24,
   parameter int COEFF_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rfpf_pkg::alu_op_type   op,
   input  rfpf_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SAMPLE_BITS-1:0] rsp_sample,
   output rfpf_pkg::status_type   status
);
   localparam int PROD_BITS    = COEFF_BITS + STATE_BITS + 1;
   localparam int BASE_BITS    = (PROD_BITS > SAMPLE_BITS + 1) ? PROD_BITS : SAMPLE_BITS + 1;
   localparam int WIDE_BITS    = BASE_BITS + 2;
   localparam int FB_FRAC_BITS = COEFF_BITS - 4;
   localparam int NUM_STAGES   = 4;

   typedef logic signed [WIDE_BITS-1:0] wide_type;

   function automatic wide_type sat(input wide_type v, input int n);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (n - 1)) - wide_type'(1);
      lo = ~hi;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [STATE_BITS-1:0]  ring_ff [NUM_STAGES];
   logic signed [STATE_BITS-1:0]  prev_ff;
   logic signed [STATE_BITS-1:0]  diff_ff;
   logic signed [STATE_BITS-1:0]  diff_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic [SAMPLE_BITS-1:0]        out_ff;
   logic [SAMPLE_BITS-1:0]        out_in;
   logic                          rsp_valid_ff;

   logic [31:0]                   cut_wide;
   logic [31:0]                   fb_wide;
   logic [COEFF_BITS-1:0]         coef;
   logic signed [COEFF_BITS:0]    coef_s;

   wide_type s0_w, s1_w, s3_w, x_w, prev_w, prod_w;
   wide_type diff_fb_w, target_w, update_w, diff_w, sel_w, out_w;
   logic signed [STATE_BITS-1:0]  update_v;
   logic                          rsp_busy;
   logic                          out_load;

   assign cut_wide = {16'd0, cfg.cutoff};
   assign fb_wide  = {16'd0, cfg.feedback};
   assign coef     = (op == rfpf_pkg::OP_MUL_FB) ? fb_wide[COEFF_BITS-1:0]
                                                 : cut_wide[COEFF_BITS-1:0];
   assign coef_s   = $signed({1'b0, coef});
   assign prod_in  = PROD_BITS'(coef_s) * PROD_BITS'(diff_ff);

   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign req_ready = (op == rfpf_pkg::OP_LOAD_IN);
   assign out_load  = (op == rfpf_pkg::OP_OUTPUT) && !rsp_busy;

   always_comb begin
      s0_w   = wide_type'(ring_ff[0]);
      s1_w   = wide_type'(ring_ff[1]);
      s3_w   = wide_type'(ring_ff[NUM_STAGES-1]);
      x_w    = wide_type'(x_ff);
      prev_w = wide_type'(prev_ff);
      prod_w = wide_type'(prod_ff);

      diff_fb_w = sat(s0_w - s1_w, STATE_BITS);
      // drive of stage one with resonance added
      target_w  = sat(sat(x_w - s0_w, STATE_BITS + 1) + (prod_w >>> FB_FRAC_BITS),
                      STATE_BITS);
      update_w  = sat(s0_w + (prod_w >>> COEFF_BITS), STATE_BITS);
      diff_w    = sat(prev_w - s0_w, STATE_BITS);
      update_v  = update_w[STATE_BITS-1:0];

      // ring is back in order at the output step: ring[0] = s0, last = s3
      case (cfg.mode)
         rfpf_pkg::MODE_LOWPASS:  sel_w = s3_w;
         rfpf_pkg::MODE_HIGHPASS: sel_w = x_w - s3_w;
         rfpf_pkg::MODE_BANDPASS: sel_w = s0_w - s3_w;
         default:                 sel_w = '0;
      endcase
      out_w  = sat(sel_w, SAMPLE_BITS);
      out_in = out_w[SAMPLE_BITS-1:0];

      case (op)
         rfpf_pkg::OP_DIFF_FB: diff_in = diff_fb_w[STATE_BITS-1:0];
         rfpf_pkg::OP_TARGET:  diff_in = target_w[STATE_BITS-1:0];
         rfpf_pkg::OP_DIFF:    diff_in = diff_w[STATE_BITS-1:0];
         default:              diff_in = diff_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (op == rfpf_pkg::OP_UPDATE) begin
         for (int i = 0; i < NUM_STAGES - 1; i++) begin
            ring_ff[i] <= ring_ff[i+1];
         end
         ring_ff[NUM_STAGES-1] <= update_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         x_ff <= req_sample;
      end
      if (op == rfpf_pkg::OP_UPDATE) begin
         prev_ff <= update_v;
      end
      diff_ff <= diff_in;
      if (op == rfpf_pkg::OP_MUL_FB || op == rfpf_pkg::OP_MUL_A) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = out_ff;
   assign status.req_valid = req_valid;
   assign status.rsp_busy  = rsp_busy;
endmodule
`default_nettype wire

FILE: src/resonant_four_pole_filter.sv
// Resonant four-pole cascade filter: four one-pole stages with resonance feedback.
//
// Samples arrive on req_chan (valid/ready, one signed sample per transfer) and
// filtered samples leave on rsp_chan, one result per input sample, in order.
// A microcoded sequencer runs a 16-step program per sample over one shared
// multiplier: five products (resonance plus four stages), each followed by a
// saturating add, with the stage values held in a rotating register ring.
// A new sample is taken only after the result of the previous one has been
// loaded into the output register.
// The APB port sets the cutoff coefficient, feedback gain and output mode
// (lowpass, highpass, bandpass); write it only while the filter is idle.
// Reset clears the four stages, sets the registers to their defaults and
// starts the program at its input step.
// If the receiver stalls, the finished result waits in the output register;
// the next sample is still taken and processed, and the program holds at its
// output step until the register is free.
`default_nettype none
module resonant_four_pole_filter #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 24,
   parameter int COEFF_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   rfpf_req_if.sink                           req_chan,
   rfpf_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rfpf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [rfpf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [rfpf_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   rfpf_pkg::cfg_type      cfg;
   rfpf_pkg::alu_op_type   op;
   rfpf_pkg::status_type   status;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic [SAMPLE_BITS-1:0] rsp_sample;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_sample          = req_chan.sample_in;
   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.sample_out = rsp_sample;

   rfpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rfpf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   rfpf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STATE_BITS  (STATE_BITS),
      .COEFF_BITS  (COEFF_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .cfg        (cfg),
      .req_valid  (req_chan.valid),
      .req_sample (req_sample),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .rsp_sample (rsp_sample),
      .status     (status)
   );
endmodule
`default_nettype wire
